// File: rtl/core/fixed_length_packet_deframer_core_macros.svh
// Assertion macros shared by the deframer's checker.
// Depends on nothing; the using module must provide clk and arst_n.
`ifndef FIXED_LENGTH_PACKET_DEFRAMER_CORE_MACROS_SVH
`define FIXED_LENGTH_PACKET_DEFRAMER_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FLPD_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("deframer check failed");

// Consequent must hold in the cycle after the antecedent.
`define FLPD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("deframer check failed");

`endif

// File: rtl/core/flpd_pkg.sv
// Shared types and constants of the fixed-length packet deframer.
// Depends on nothing.
package flpd_pkg;

	localparam int BYTE_W = 8;
	localparam int IDX_W  = 4;
	localparam int REJ_W  = 16;

	localparam logic [BYTE_W-1:0] HEAD_MARK  = 8'hA5;
	localparam logic [BYTE_W-1:0] TAIL_MARK  = 8'h5A;
	localparam logic [REJ_W-1:0]  REJECT_MAX = 16'hFFFF;

	// Status of the window for the byte now presented to it.
	typedef struct packed {
		logic             hit;     // this byte completes a valid packet
		logic [REJ_W-1:0] rejects; // reject count before this byte
	} win_stat_t;

endpackage

// File: rtl/core/fixed_length_packet_deframer_core.sv
// Top level of the fixed-length packet deframer.
// Depends on flpd_pkg, flpd_window and flpd_burst.
//
// The deframer takes one received byte per word and watches the last
// PAYLOAD_LEN + 3 bytes: a head of 0xA5, PAYLOAD_LEN payload bytes, a checksum
// equal to the low byte of the payload sum, and a tail of 0x5A. Once that many
// bytes have arrived since reset or since the last good packet, every new byte
// completes a candidate packet. A good packet is emitted as PAYLOAD_LEN output
// words (payload byte, its index, a last mark and the reject count at that
// moment) and clears the fill count, so overlapping candidates are skipped; a
// bad candidate bumps a reject counter that sticks at 0xFFFF. Rate: one byte
// is accepted every cycle unless the input stalls; an accepted byte is held in
// the input register and checked as it leaves it, and the words of a good
// packet are presented from the result register once it is loaded, one per
// cycle while the output side takes them. Because a good packet blocks the
// next PAYLOAD_LEN + 2 bytes from completing another, the single result
// register drains in time whenever the output side takes words freely; the
// input stalls only when a new good packet completes while the previous burst
// is still held back by the output side.
module fixed_length_packet_deframer_core #(
	parameter int PAYLOAD_LEN = 3
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [flpd_pkg::BYTE_W-1:0]   rx_byte,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [flpd_pkg::BYTE_W-1:0]   payload_byte,
	output logic [flpd_pkg::IDX_W-1:0]    byte_index,
	output logic                          is_last,
	output logic [flpd_pkg::REJ_W-1:0]    rejected_count
);

	logic [flpd_pkg::BYTE_W-1:0]              rx_byte_s1;
	logic                                     valid_s1;
	logic                                     advance;
	logic                                     burst_free;
	flpd_pkg::win_stat_t                      win_stat;
	logic [PAYLOAD_LEN*flpd_pkg::BYTE_W-1:0]  win_payload;

	// The held byte moves on unless it completes a good packet while the
	// result register still has words from the previous one to give out.
	assign advance  = valid_s1 && (!win_stat.hit || burst_free);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	flpd_window #(
		.PAYLOAD_LEN(PAYLOAD_LEN)
	) u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.rx_byte (rx_byte_s1),
		.stat    (win_stat),
		.payload (win_payload)
	);

	flpd_burst #(
		.PAYLOAD_LEN(PAYLOAD_LEN)
	) u_burst (
		.clk            (clk),
		.arst_n         (arst_n),
		.load           (advance && win_stat.hit),
		.load_payload   (win_payload),
		.load_rejects   (win_stat.rejects),
		.free           (burst_free),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.payload_byte   (payload_byte),
		.byte_index     (byte_index),
		.is_last        (is_last),
		.rejected_count (rejected_count)
	);

endmodule

// File: rtl/core/flpd_window.sv
// Packet window: shift line of the last packet-length bytes, running payload sum,
// fill count, packet check and saturating reject counter. Depends on flpd_pkg.
module flpd_window #(
	parameter int PAYLOAD_LEN = 3
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     step,
	input  logic [flpd_pkg::BYTE_W-1:0]              rx_byte,
	output flpd_pkg::win_stat_t                      stat,
	output logic [PAYLOAD_LEN*flpd_pkg::BYTE_W-1:0]  payload
);

	localparam int BW      = flpd_pkg::BYTE_W;
	localparam int PKT_LEN = PAYLOAD_LEN + 3;
	localparam int CNT_W   = $clog2(PKT_LEN + 1);
	localparam logic [CNT_W-1:0] PKT_LEN_C  = CNT_W'(PKT_LEN);
	localparam logic [CNT_W-1:0] NEAR_FULL  = CNT_W'(PKT_LEN - 1);

	logic [BW-1:0]                 win_q [PKT_LEN];
	logic [CNT_W-1:0]              cnt_q;
	logic [BW-1:0]                 psum_q;
	logic [flpd_pkg::REJ_W-1:0]    rej_q;

	logic [BW-1:0]    psum_new;
	logic [CNT_W-1:0] cnt_next;
	logic             full;
	logic             hit;

	// The payload sum moves with the window: the byte entering the payload
	// region is added, the byte that becomes the head leaves it.
	assign psum_new = psum_q - win_q[1] + win_q[PAYLOAD_LEN + 1];
	assign cnt_next = (cnt_q == PKT_LEN_C) ? cnt_q : cnt_q + 1'b1;
	assign full     = (cnt_q >= NEAR_FULL);
	assign hit      = full && (win_q[1] == flpd_pkg::HEAD_MARK)
		&& (rx_byte == flpd_pkg::TAIL_MARK) && (win_q[PKT_LEN - 1] == psum_new);

	assign stat.hit     = hit;
	assign stat.rejects = rej_q;

	always_comb begin
		for (int i = 0; i < PAYLOAD_LEN; i++) begin
			payload[i*BW +: BW] = win_q[i + 2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PKT_LEN; i++) begin
				win_q[i] <= '0;
			end
			cnt_q  <= '0;
			psum_q <= '0;
			rej_q  <= '0;
		end else if (step) begin
			for (int i = 0; i < PKT_LEN - 1; i++) begin
				win_q[i] <= win_q[i + 1];
			end
			win_q[PKT_LEN - 1] <= rx_byte;
			psum_q <= psum_new;
			cnt_q  <= hit ? '0 : cnt_next;
			if (full && !hit && (rej_q != flpd_pkg::REJECT_MAX)) begin
				rej_q <= rej_q + 1'b1;
			end
		end
	end

endmodule

// File: rtl/core/flpd_burst.sv
// Result register: holds the payload of one accepted packet and hands it out
// one word per ready cycle with its index and last mark. Depends on flpd_pkg.
module flpd_burst #(
	parameter int PAYLOAD_LEN = 3
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     load,
	input  logic [PAYLOAD_LEN*flpd_pkg::BYTE_W-1:0]  load_payload,
	input  logic [flpd_pkg::REJ_W-1:0]               load_rejects,
	output logic                                     free,
	output logic                                     out_valid,
	input  logic                                     out_ready,
	output logic [flpd_pkg::BYTE_W-1:0]              payload_byte,
	output logic [flpd_pkg::IDX_W-1:0]               byte_index,
	output logic                                     is_last,
	output logic [flpd_pkg::REJ_W-1:0]               rejected_count
);

	localparam int BW    = flpd_pkg::BYTE_W;
	localparam int IDX_W = flpd_pkg::IDX_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PAYLOAD_LEN - 1);

	logic [PAYLOAD_LEN*BW-1:0]     data_q;
	logic [IDX_W-1:0]              idx_q;
	logic [flpd_pkg::REJ_W-1:0]    rej_q;
	logic                          busy_q;

	assign out_valid      = busy_q;
	assign payload_byte   = data_q[BW-1:0];
	assign byte_index     = idx_q;
	assign is_last        = (idx_q == LAST_IDX);
	assign rejected_count = rej_q;
	assign free           = !busy_q || (out_ready && is_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (busy_q && out_ready) begin
			idx_q <= idx_q + 1'b1;
			if (is_last) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= load_payload;
			rej_q  <= load_rejects;
		end else if (busy_q && out_ready) begin
			data_q <= data_q >> BW;
		end
	end

endmodule

// File: rtl/core/flpd_checker.sv
// Port-level checks of the deframer's output bursts, bound to the top level.
// Depends on flpd_pkg and fixed_length_packet_deframer_core_macros.svh.
`include "fixed_length_packet_deframer_core_macros.svh"

module flpd_checker #(
	parameter int PAYLOAD_LEN = 3
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [flpd_pkg::BYTE_W-1:0]   payload_byte,
	input logic [flpd_pkg::IDX_W-1:0]    byte_index,
	input logic                          is_last,
	input logic [flpd_pkg::REJ_W-1:0]    rejected_count
);

	localparam int IDX_W = flpd_pkg::IDX_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PAYLOAD_LEN - 1);

	// A held word stays put.
	`FLPD_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(payload_byte) && $stable(byte_index))

	// A burst never breaks off before its last word.
	`FLPD_ASSERT_NEXT(a_burst_on, out_valid && out_ready && !is_last, out_valid && (byte_index == $past(byte_index) + 1'b1) && (rejected_count == $past(rejected_count)))

	// The last mark sits exactly on the final payload index.
	`FLPD_ASSERT_NOW(a_last_idx, out_valid, is_last == (byte_index == LAST_IDX))

endmodule

bind fixed_length_packet_deframer_core flpd_checker #(
	.PAYLOAD_LEN(PAYLOAD_LEN)
) u_flpd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.payload_byte   (payload_byte),
	.byte_index     (byte_index),
	.is_last        (is_last),
	.rejected_count (rejected_count)
);

// File: verif/fixed_length_packet_deframer_core_tb.sv
// Self-checking testbench for fixed_length_packet_deframer_core, payload length three.
// Depends on flpd_pkg and the deframer RTL; it predicts every payload word from the
// received bytes and checks the output stream word by word.
module fixed_length_packet_deframer_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PAYLOAD_LEN = 3;
	localparam int PKT_LEN     = PAYLOAD_LEN + 3;
	// Cycles with no word moving on either side before the run is declared hung.
	localparam int STALL_LIMIT = 2000;
	// Cycles allowed after the last expected word, in case a stray word follows.
	localparam int TAIL_WAIT   = PKT_LEN + 6;

	typedef logic [flpd_pkg::BYTE_W-1:0] octet_t;

	// One payload word as the deframer presents it.
	typedef struct packed {
		octet_t                      data;
		logic [flpd_pkg::IDX_W-1:0]  idx;
		logic                        last;
		logic [flpd_pkg::REJ_W-1:0]  rejects;
	} payload_word_t;

	// Ways in which a sent packet may be deliberately broken.
	typedef enum logic [1:0] {
		FLAW_NONE,
		FLAW_HEAD,
		FLAW_SUM,
		FLAW_TAIL
	} flaw_t;

	logic                        clk;
	logic                        arst_n;
	logic                        in_valid;
	logic                        in_ready;
	octet_t                      rx_byte;
	logic                        out_valid;
	logic                        out_ready;
	octet_t                      payload_byte;
	logic [flpd_pkg::IDX_W-1:0]  byte_index;
	logic                        is_last;
	logic [flpd_pkg::REJ_W-1:0]  rejected_count;

	fixed_length_packet_deframer_core #(
		.PAYLOAD_LEN(PAYLOAD_LEN)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.rx_byte       (rx_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.payload_byte  (payload_byte),
		.byte_index    (byte_index),
		.is_last       (is_last),
		.rejected_count(rejected_count)
	);

	// Predictor state: our own copy of the byte window, the fill count since the
	// last good packet and the saturating reject count.
	octet_t                      rx_window [PKT_LEN];
	int                          fill_count;
	logic [flpd_pkg::REJ_W-1:0]  reject_total;

	// Payload words that the deframer still owes us, oldest first.
	payload_word_t   payload_words_q [$];

	// Traffic shaping, set by the tests and read by the driving processes.
	bit              sender_gaps;
	bit              receiver_gaps;
	int              hold_request;

	// Run statistics for the summary.
	int              bytes_sent;
	int              good_packets;
	int              rejected_windows;
	int              words_checked;
	int              mismatches;
	int              longest_input_stall;
	int              idle_cycles;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Advance the predicted window by one received byte and queue any payload
	// words that a completed good packet produces.
	function automatic void deframe_byte(input octet_t b);
		octet_t        sum;
		payload_word_t w;
		for (int i = 0; i < PKT_LEN - 1; i++)
			rx_window[i] = rx_window[i + 1];
		rx_window[PKT_LEN - 1] = b;
		if (fill_count < PKT_LEN)
			fill_count++;
		// Until a whole packet's worth of bytes has arrived since reset or the
		// last good packet, nothing is examined and nothing is rejected.
		if (fill_count < PKT_LEN)
			return;
		// The checksum is the payload sum truncated to a byte.
		sum = '0;
		for (int i = 1; i <= PAYLOAD_LEN; i++)
			sum += rx_window[i];
		if (rx_window[0] != flpd_pkg::HEAD_MARK ||
				rx_window[PKT_LEN - 1] != flpd_pkg::TAIL_MARK ||
				rx_window[PKT_LEN - 2] != sum) begin
			rejected_windows++;
			if (reject_total != flpd_pkg::REJECT_MAX)
				reject_total++;
			return;
		end
		fill_count = 0;
		good_packets++;
		for (int i = 0; i < PAYLOAD_LEN; i++) begin
			w.data    = rx_window[1 + i];
			w.idx     = i[flpd_pkg::IDX_W-1:0];
			w.last    = (i == PAYLOAD_LEN - 1);
			w.rejects = reject_total;
			payload_words_q.push_back(w);
		end
	endfunction

	// Offer one byte on the input side and hold it until the deframer takes it.
	// Valid is only dropped when a gap is inserted, so it never falls and rises
	// within the same time step.
	task automatic send_byte(input octet_t b);
		int unsigned gap;
		int          waited;
		gap = 0;
		waited = 0;
		if (sender_gaps && $urandom_range(0, 4) == 0)
			gap = $urandom_range(1, 12);
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		@(posedge clk);
		while (!in_ready) begin
			waited++;
			@(posedge clk);
		end
		if (waited > longest_input_stall)
			longest_input_stall = waited;
		bytes_sent++;
		deframe_byte(b);
	endtask

	// Bias payload bytes towards the marker values and the byte extremes, since
	// those are where framing mistakes tend to hide.
	function automatic octet_t pick_octet();
		int unsigned sel;
		sel = $urandom_range(0, 7);
		if (sel == 0)
			return flpd_pkg::HEAD_MARK;
		else if (sel == 1)
			return flpd_pkg::TAIL_MARK;
		else if (sel == 2)
			return '1;
		else if (sel == 3)
			return '0;
		return octet_t'($urandom);
	endfunction

	function automatic logic [PAYLOAD_LEN*flpd_pkg::BYTE_W-1:0] pick_payload();
		logic [PAYLOAD_LEN*flpd_pkg::BYTE_W-1:0] body;
		for (int i = 0; i < PAYLOAD_LEN; i++)
			body[i*flpd_pkg::BYTE_W +: flpd_pkg::BYTE_W] = pick_octet();
		return body;
	endfunction

	// Send head, payload (byte 0 first), checksum and tail, optionally breaking
	// one of the framing bytes.
	task automatic send_packet(input logic [PAYLOAD_LEN*flpd_pkg::BYTE_W-1:0] body,
			input flaw_t flaw);
		octet_t sum;
		octet_t head;
		octet_t chk;
		octet_t tail;
		sum = '0;
		for (int i = 0; i < PAYLOAD_LEN; i++)
			sum += body[i*flpd_pkg::BYTE_W +: flpd_pkg::BYTE_W];
		head = flpd_pkg::HEAD_MARK;
		chk  = sum;
		tail = flpd_pkg::TAIL_MARK;
		case (flaw)
			FLAW_HEAD: begin
				head ^= octet_t'($urandom_range(1, 255));
			end
			FLAW_SUM: begin
				chk ^= octet_t'($urandom_range(1, 255));
			end
			FLAW_TAIL: begin
				tail ^= octet_t'($urandom_range(1, 255));
			end
			default: begin
			end
		endcase
		send_byte(head);
		for (int i = 0; i < PAYLOAD_LEN; i++)
			send_byte(body[i*flpd_pkg::BYTE_W +: flpd_pkg::BYTE_W]);
		send_byte(chk);
		send_byte(tail);
	endtask

	// A good packet straight after reset is accepted on the very byte that
	// fills the window. Two further bytes then complete a window that would also
	// pass the check, but it overlaps the packet just taken and must be skipped.
	// The sequence is laid out for a three-byte payload.
	task automatic test_fill_and_overlap();
		send_packet({8'h00, flpd_pkg::HEAD_MARK, 8'h00}, FLAW_NONE);
		send_byte(8'hFF);
		send_byte(flpd_pkg::TAIL_MARK);
	endtask

	// All-ones payload: the payload sum overflows a byte and only its low byte
	// is carried in the checksum.
	task automatic test_checksum_wrap();
		send_packet({PAYLOAD_LEN{8'hFF}}, FLAW_NONE);
	endtask

	// One broken packet per framing byte; each bumps the reject count that the
	// next good packet reports.
	task automatic test_broken_frames();
		send_packet(pick_payload(), FLAW_HEAD);
		send_packet(pick_payload(), FLAW_SUM);
		send_packet(pick_payload(), FLAW_TAIL);
		send_packet({PAYLOAD_LEN{8'h00}}, FLAW_NONE);
	endtask

	// Mostly well-formed packets with random payloads, mixed with broken packets
	// and runs of line noise. Gaps on both sides are switched on and off in
	// stretches so that some of the traffic runs at full rate.
	task automatic test_random_traffic(input int n_bytes);
		int          first;
		int unsigned pick;
		int unsigned run;
		first = bytes_sent;
		while (bytes_sent - first < n_bytes) begin
			if ($urandom_range(0, 7) == 0) begin
				sender_gaps   = ($urandom_range(0, 2) != 0);
				receiver_gaps = ($urandom_range(0, 2) != 0);
			end
			pick = $urandom_range(0, 9);
			if (pick < 6) begin
				send_packet(pick_payload(), FLAW_NONE);
			end else if (pick < 8) begin
				send_packet(pick_payload(), flaw_t'($urandom_range(1, 3)));
			end else begin
				run = $urandom_range(1, 5);
				repeat (run) send_byte(octet_t'($urandom));
			end
		end
	endtask

	// The output side holds off for a long stretch while good packets keep
	// arriving back to back, so the deframer backs up and stalls its input.
	task automatic test_output_backpressure();
		sender_gaps   = 1'b0;
		receiver_gaps = 1'b0;
		hold_request  = 80;
		repeat (6) send_packet(pick_payload(), FLAW_NONE);
	endtask

	// A stretch of line noise at full rate, where every byte once the window has
	// refilled is a rejected window, followed by good packets that must report
	// the grown reject count. No gaps from here on.
	task automatic test_line_noise();
		sender_gaps   = 1'b0;
		receiver_gaps = 1'b0;
		repeat (30) send_byte(octet_t'($urandom));
		repeat (2) send_packet(pick_payload(), FLAW_NONE);
	endtask

	// Output side: random stalls in bursts, plus a long hold-off on request that
	// is counted down here.
	initial begin : output_side
		int hold_left;
		int burst_left;
		hold_left  = 0;
		burst_left = 0;
		out_ready  = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request != 0) begin
				hold_left    = hold_request;
				hold_request = 0;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (burst_left != 0) begin
				burst_left--;
				out_ready <= 1'b0;
			end else if (receiver_gaps && $urandom_range(0, 4) == 0) begin
				burst_left = $urandom_range(1, 12) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Every payload word taken from the deframer is compared with the oldest
	// prediction, field by field.
	always @(posedge clk) begin : word_check
		payload_word_t exp_w;
		if (arst_n && out_valid && out_ready) begin
			if (payload_words_q.size() == 0) begin
				$error("payload word %h (index %0d) arrived with nothing expected",
					payload_byte, byte_index);
				mismatches++;
			end else begin
				exp_w = payload_words_q.pop_front();
				words_checked++;
				if (payload_byte !== exp_w.data) begin
					$error("payload_byte: expected %h, got %h", exp_w.data, payload_byte);
					mismatches++;
				end
				if (byte_index !== exp_w.idx) begin
					$error("byte_index: expected %0d, got %0d", exp_w.idx, byte_index);
					mismatches++;
				end
				if (is_last !== exp_w.last) begin
					$error("is_last: expected %b, got %b", exp_w.last, is_last);
					mismatches++;
				end
				if (rejected_count !== exp_w.rejects) begin
					$error("rejected_count: expected %0d, got %0d", exp_w.rejects,
						rejected_count);
					mismatches++;
				end
			end
		end
	end

	// Watchdog: a run in which no word moves on either side for too long is hung.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Watchdog: no word moved for %0d cycles, %0d words still owed",
				idle_cycles, payload_words_q.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		arst_n              = 1'b0;
		in_valid            = 1'b0;
		rx_byte             = '0;
		sender_gaps         = 1'b0;
		receiver_gaps       = 1'b0;
		hold_request        = 0;
		bytes_sent          = 0;
		good_packets        = 0;
		rejected_windows    = 0;
		words_checked       = 0;
		mismatches          = 0;
		longest_input_stall = 0;
		idle_cycles         = 0;
		fill_count          = 0;
		reject_total        = '0;
		foreach (rx_window[i])
			rx_window[i] = '0;

		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		test_fill_and_overlap();
		test_checksum_wrap();
		test_broken_frames();
		test_random_traffic(250);
		test_output_backpressure();
		test_line_noise();

		@(negedge clk);
		in_valid <= 1'b0;
		while (payload_words_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_WAIT) @(posedge clk);

		$display("Sent %0d bytes: %0d good packets, %0d rejected windows, %0d words checked.",
			bytes_sent, good_packets, rejected_windows, words_checked);
		$display("Longest input stall %0d cycles; final reject count %0d.",
			longest_input_stall, reject_total);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
